// ===== hdl/ymr_pkg.sv =====
// Package for the YModem receiver: types, protocol byte codes, phase codes
// and the CRC-16/XMODEM byte step. No dependencies.
package ymr_pkg;

	localparam int SIZE_WIDTH = 24;
	localparam int ERROR_LIMIT = 5;

	localparam logic [7:0] B_SOH = 8'h01;
	localparam logic [7:0] B_STX = 8'h02;
	localparam logic [7:0] B_EOT = 8'h04;
	localparam logic [7:0] B_ACK = 8'h06;
	localparam logic [7:0] B_NAK = 8'h15;
	localparam logic [7:0] B_CA = 8'h18;
	localparam logic [7:0] B_C = 8'h43;
	localparam logic [7:0] B_UA = 8'h41;
	localparam logic [7:0] B_LA = 8'h61;

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_CAN = 3'd1;
	localparam logic [2:0] PH_PKT = 3'd2;
	localparam logic [2:0] PH_DRAIN = 3'd3;
	localparam logic [2:0] PH_OVER = 3'd4;

	localparam logic [1:0] HF_NAME = 2'd0;
	localparam logic [1:0] HF_SIZE = 2'd1;
	localparam logic [1:0] HF_REST = 2'd2;

	localparam logic [3:0] ST_RUN = 4'd0;
	localparam logic [3:0] ST_OK = 4'd1;
	localparam logic [3:0] ST_SENDER = 4'd2;
	localparam logic [3:0] ST_CRC = 4'd3;
	localparam logic [3:0] ST_SEQ = 4'd4;
	localparam logic [3:0] ST_ZERO = 4'd5;
	localparam logic [3:0] ST_EMPTY = 4'd6;
	localparam logic [3:0] ST_USER = 4'd7;
	localparam logic [3:0] ST_TIMEOUT = 4'd8;
	localparam logic [3:0] ST_LARGE = 4'd9;

	localparam logic [15:0] CRC_POLY = 16'h1021;

	typedef logic [SIZE_WIDTH-1:0] size_t;

	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        write_valid;
		size_t       write_addr;
		logic [7:0]  write_data;
		logic        commit_valid;
		size_t       received_length;
		logic        done_res;
		logic [3:0]  status;
		size_t       hdr_size;
		logic        last;
	} res_t;

	// Both result items of one event and how many of them are real
	typedef struct packed {
		logic two;
		res_t r0;
		res_t r1;
	} res_pair_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
			else c = {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// ===== hdl/ymr_if.sv =====
// Channel interfaces of the YModem receiver: input events, results and
// the configuration write channel. Depends on ymr_pkg.
interface ymr_in_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] rx_byte;
	modport source (output valid, output operation, output rx_byte, input ready);
	modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

interface ymr_out_if;
	logic          valid;
	logic          ready;
	ymr_pkg::res_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ymr_cfg_if;
	logic                 valid;
	logic                 ready;
	ymr_pkg::size_t       data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/ymr_core.sv =====
// Protocol engine of the YModem receiver: session state and the per-event
// next-state and result logic. Depends on ymr_pkg.
module ymr_core #(
	parameter int MAX_TIMEOUTS = 5,
	parameter int SIZE_FIELD_CHARS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               ev_accept,
	input  logic               operation,
	input  logic [7:0]         rx_byte,
	input  ymr_pkg::size_t     max_size,
	output ymr_pkg::res_pair_t res
);
	localparam int SW = ymr_pkg::SIZE_WIDTH;
	localparam logic [SW-1:0] SIZE_MASK = {SW{1'b1}};

	logic [2:0]  phase_q, n_phase;
	logic [10:0] idx_q, n_idx;
	logic        long_q, n_long;
	logic [7:0]  seq_q, n_seq, comp_q, n_comp;
	logic [15:0] crc_q, n_crc;
	logic [7:0]  pkts_q, n_pkts;
	logic        hdr_q, n_hdr;
	logic [3:0]  err_q, n_err;
	logic [1:0]  eot_q, n_eot;
	logic [SW-1:0] fsize_q, n_fsize, commit_q, n_commit, acc_q, n_acc;
	logic [1:0]  hf_q, n_hf;
	logic [4:0]  scc_q, n_scc;
	logic        nne_q, n_nne, ovf_q, n_ovf, over_q, n_over;
	logic [3:0]  stat_q, n_stat;

	logic [1:0]  ntx;
	logic [7:0]  tx0, tx1;
	logic        wr_v, cm_v;
	logic [SW-1:0] wr_a;
	logic [7:0]  wr_d;
	logic        do_err, do_to;
	logic [3:0]  err_lim, err_code;
	logic [7:0]  err_rep;
	logic [4:0]  err_inc;
	logic [10:0] psize, p;
	logic [SW+3:0] acc_x10;
	logic [SW:0] sum;

	always_comb begin
		n_phase = phase_q; n_idx = idx_q; n_long = long_q; n_seq = seq_q; n_comp = comp_q;
		n_crc = crc_q; n_pkts = pkts_q; n_hdr = hdr_q; n_err = err_q; n_eot = eot_q;
		n_fsize = fsize_q; n_commit = commit_q; n_acc = acc_q; n_hf = hf_q; n_scc = scc_q;
		n_nne = nne_q; n_ovf = ovf_q; n_over = over_q; n_stat = stat_q;
		ntx = 2'd0; tx0 = '0; tx1 = '0; wr_v = 1'b0; cm_v = 1'b0; wr_a = '0; wr_d = '0;
		do_err = 1'b0; do_to = 1'b0; err_lim = '0; err_code = '0; err_rep = '0;
		err_inc = '0;
		psize = long_q ? 11'd1024 : 11'd128;
		p = idx_q - 11'd2;
		acc_x10 = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + {{SW{1'b0}}, rx_byte[3:0]};
		sum = '0;
		unique case (phase_q)
			ymr_pkg::PH_IDLE: begin
				if (operation) do_to = 1'b1;
				else begin
					case (rx_byte)
						ymr_pkg::B_SOH, ymr_pkg::B_STX: begin
							n_phase = ymr_pkg::PH_PKT;
							n_long = (rx_byte == ymr_pkg::B_STX);
							n_idx = '0; n_crc = '0; n_hf = ymr_pkg::HF_NAME;
							n_scc = '0; n_acc = '0; n_nne = 1'b0; n_ovf = 1'b0;
						end
						ymr_pkg::B_EOT: begin
							if (eot_q < 2'd2) n_eot = eot_q + 2'd1;
							if (n_eot == 2'd1) begin
								ntx = 2'd1; tx0 = ymr_pkg::B_NAK;
							end else begin
								ntx = 2'd2; tx0 = ymr_pkg::B_ACK; tx1 = ymr_pkg::B_C;
							end
						end
						ymr_pkg::B_CA: n_phase = ymr_pkg::PH_CAN;
						ymr_pkg::B_UA, ymr_pkg::B_LA: begin
							ntx = 2'd2; tx0 = ymr_pkg::B_CA; tx1 = ymr_pkg::B_CA;
							n_over = 1'b1; n_stat = ymr_pkg::ST_USER; n_phase = ymr_pkg::PH_OVER;
						end
						default: n_phase = ymr_pkg::PH_DRAIN;
					endcase
				end
			end
			ymr_pkg::PH_CAN: begin
				if (operation) begin
					ntx = 2'd2; tx0 = ymr_pkg::B_CA; tx1 = ymr_pkg::B_CA;
					n_over = 1'b1; n_stat = ymr_pkg::ST_USER; n_phase = ymr_pkg::PH_OVER;
				end else if (rx_byte == ymr_pkg::B_CA) begin
					ntx = 2'd1; tx0 = ymr_pkg::B_ACK;
					n_over = 1'b1; n_stat = ymr_pkg::ST_SENDER; n_phase = ymr_pkg::PH_OVER;
				end else begin
					n_phase = ymr_pkg::PH_IDLE; do_to = 1'b1;
				end
			end
			ymr_pkg::PH_PKT: begin
				if (operation) begin
					n_phase = ymr_pkg::PH_IDLE; do_to = 1'b1;
				end else begin
					if (idx_q == 11'd0) n_seq = rx_byte;
					else if (idx_q == 11'd1) n_comp = rx_byte;
					else begin
						n_crc = ymr_pkg::crc_byte(crc_q, rx_byte);
						if (p < psize) begin
							// header fields: name up to NUL, then decimal size
							if (p == 11'd0) n_nne = (rx_byte != 8'd0);
							if (hf_q == ymr_pkg::HF_NAME) begin
								if (rx_byte == 8'd0) n_hf = ymr_pkg::HF_SIZE;
							end else if (hf_q == ymr_pkg::HF_SIZE) begin
								if (rx_byte >= 8'h30 && rx_byte <= 8'h39 &&
								    scc_q < 5'(SIZE_FIELD_CHARS)) begin
									if (acc_x10 > {4'd0, SIZE_MASK}) begin
										n_ovf = 1'b1; n_acc = SIZE_MASK;
									end else n_acc = acc_x10[SW-1:0];
									n_scc = scc_q + 5'd1;
								end else n_hf = ymr_pkg::HF_REST;
							end
							if (hdr_q && eot_q < 2'd2 && seq_q == pkts_q && seq_q == ~comp_q &&
							    ({1'b0, commit_q} + {{(SW-10){1'b0}}, p[9:0] | {p[10], 10'd0}})
							    < {1'b0, fsize_q}) begin
								wr_v = 1'b1;
								wr_a = commit_q + SW'(p);
								wr_d = rx_byte;
							end
						end
					end
					if (idx_q >= psize + 11'd3) begin
						n_phase = ymr_pkg::PH_IDLE;
						if (!(seq_q == ~comp_q && n_crc == 16'd0)) begin
							do_err = 1'b1; err_lim = 4'(ymr_pkg::ERROR_LIMIT);
							err_code = ymr_pkg::ST_CRC; err_rep = ymr_pkg::B_NAK;
						end else if (eot_q > 2'd1) begin
							ntx = 2'd1; tx0 = ymr_pkg::B_ACK;
						end else if (seq_q != pkts_q) begin
							do_err = 1'b1; err_lim = 4'(ymr_pkg::ERROR_LIMIT);
							err_code = ymr_pkg::ST_SEQ; err_rep = ymr_pkg::B_NAK;
						end else if (!hdr_q) begin
							n_hdr = 1'b1; n_pkts = pkts_q + 8'd1;
							if (!nne_q) begin
								do_err = 1'b1; err_lim = 4'(ymr_pkg::ERROR_LIMIT);
								err_code = ymr_pkg::ST_EMPTY; err_rep = ymr_pkg::B_NAK;
							end else begin
								n_err = '0; n_fsize = acc_q;
								if (ovf_q || acc_q > max_size || acc_q == '0) begin
									n_hdr = hdr_q; n_pkts = pkts_q;
									ntx = 2'd2; tx0 = ymr_pkg::B_CA; tx1 = ymr_pkg::B_CA;
									n_over = 1'b1; n_phase = ymr_pkg::PH_OVER;
									n_stat = (acc_q == '0 && !ovf_q) ? ymr_pkg::ST_ZERO
									                                 : ymr_pkg::ST_LARGE;
								end else begin
									n_commit = '0;
									ntx = 2'd2; tx0 = ymr_pkg::B_ACK; tx1 = ymr_pkg::B_C;
								end
							end
						end else begin
							sum = {1'b0, commit_q} + (SW+1)'(psize);
							n_commit = (sum >= {1'b0, fsize_q}) ? fsize_q : sum[SW-1:0];
							n_err = '0; cm_v = 1'b1;
							ntx = 2'd1; tx0 = ymr_pkg::B_ACK;
							n_pkts = pkts_q + 8'd1;
						end
					end else n_idx = idx_q + 11'd1;
				end
			end
			ymr_pkg::PH_DRAIN: begin
				if (operation) begin
					n_phase = ymr_pkg::PH_IDLE; do_to = 1'b1;
				end
			end
			default: ;
		endcase
		// timeout: ends after two EOTs, else counts toward the timeout limit
		if (do_to) begin
			if (eot_q > 2'd1) begin
				n_over = 1'b1; n_stat = ymr_pkg::ST_OK; n_phase = ymr_pkg::PH_OVER;
			end else begin
				do_err = 1'b1; err_lim = 4'(MAX_TIMEOUTS);
				err_code = ymr_pkg::ST_TIMEOUT; err_rep = ymr_pkg::B_C;
			end
		end
		if (do_err) begin
			err_inc = {1'b0, err_q} + 5'd1;
			if (err_inc > {1'b0, err_lim}) begin
				ntx = 2'd2; tx0 = ymr_pkg::B_CA; tx1 = ymr_pkg::B_CA;
				n_over = 1'b1; n_stat = err_code; n_phase = ymr_pkg::PH_OVER;
			end else begin
				n_err = err_inc[4] ? 4'd15 : err_inc[3:0];
				ntx = 2'd1; tx0 = err_rep;
			end
		end
	end

	always_comb begin
		res.two = (ntx == 2'd2);
		res.r0.tx_valid = (ntx != 2'd0);
		res.r0.tx_byte = tx0;
		res.r0.write_valid = wr_v;
		res.r0.write_addr = wr_a;
		res.r0.write_data = wr_d;
		res.r0.commit_valid = cm_v;
		res.r0.received_length = n_commit;
		res.r0.done_res = n_over;
		res.r0.status = n_stat;
		res.r0.hdr_size = n_fsize;
		res.r0.last = (ntx != 2'd2);
		res.r1 = res.r0;
		res.r1.tx_valid = 1'b1;
		res.r1.tx_byte = tx1;
		res.r1.write_valid = 1'b0;
		res.r1.write_addr = '0;
		res.r1.write_data = '0;
		res.r1.commit_valid = 1'b0;
		res.r1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ymr_pkg::PH_IDLE; idx_q <= '0; long_q <= 1'b0; seq_q <= '0;
			comp_q <= '0; crc_q <= '0; pkts_q <= '0; hdr_q <= 1'b0; err_q <= '0;
			eot_q <= '0; fsize_q <= '0; commit_q <= '0; acc_q <= '0;
			hf_q <= ymr_pkg::HF_NAME; scc_q <= '0; nne_q <= 1'b0; ovf_q <= 1'b0;
			over_q <= 1'b0; stat_q <= ymr_pkg::ST_RUN;
		end else if (ev_accept) begin
			phase_q <= n_phase; idx_q <= n_idx; long_q <= n_long; seq_q <= n_seq;
			comp_q <= n_comp; crc_q <= n_crc; pkts_q <= n_pkts; hdr_q <= n_hdr;
			err_q <= n_err; eot_q <= n_eot; fsize_q <= n_fsize; commit_q <= n_commit;
			acc_q <= n_acc; hf_q <= n_hf; scc_q <= n_scc; nne_q <= n_nne;
			ovf_q <= n_ovf; over_q <= n_over; stat_q <= n_stat;
		end
	end
endmodule

// ===== hdl/ymr_outq.sv =====
// Result queue of the YModem receiver: four entries, takes one or two
// result items per event, hands out one per transaction. Depends on ymr_pkg.
module ymr_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ymr_pkg::res_pair_t pair,
	output logic               room,
	output logic               out_valid,
	input  logic               out_ready,
	output ymr_pkg::res_t      out_data
);
	ymr_pkg::res_t mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic pop;

	assign pop = out_valid && out_ready;
	assign out_valid = (cnt_q != 3'd0);
	assign out_data = mem_q[rp_q];
	// leave room for a two-item event
	assign room = (cnt_q <= 3'd2);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= pair.r0;
			if (pair.two) mem_q[wp_q + 2'd1] <= pair.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + (pair.two ? 2'd2 : 2'd1);
			if (pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + (push ? (pair.two ? 3'd2 : 3'd1) : 3'd0) - (pop ? 3'd1 : 3'd0);
		end
	end
endmodule

// ===== hdl/ymodem_receiver.sv =====
// YModem-CRC receiver top level: configuration register, protocol engine
// and result queue. Depends on ymr_pkg, ymr_if, ymr_core and ymr_outq.
//
// Takes one event (received byte or timeout) per in_ch transaction and
// can accept a new event every cycle while the queue has room: the protocol
// engine updates all session state and pushes one or two result items into
// a four-entry queue. Each result item leaves as one out_ch transaction, so
// an event with a two-byte reply (ACK+C, CA+CA) takes two out_ch
// transactions; the queue depth decides when in_ch ready drops, which is
// whenever fewer than two slots are free. Results are registered in the
// queue before they reach out_ch. max_file_size is written through cfg_ch,
// always ready; write it only while no event is outstanding.
module ymodem_receiver #(
	parameter int MAX_TIMEOUTS = 5,
	parameter int SIZE_FIELD_CHARS = 16
) (
	input logic      clk,
	input logic      arst_n,
	ymr_in_if.sink   in_ch,
	ymr_out_if.source out_ch,
	ymr_cfg_if.sink  cfg_ch
);
	ymr_pkg::size_t     max_size_q;
	ymr_pkg::res_pair_t pair;
	logic               room, ev_accept;

	// configuration: single register, always takes a write
	assign cfg_ch.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) max_size_q <= ymr_pkg::SIZE_WIDTH'(3072);
		else if (cfg_ch.valid) max_size_q <= cfg_ch.data;
	end

	// hold events back only when the queue could overflow
	assign in_ch.ready = room;
	assign ev_accept = in_ch.valid && room;

	ymr_core #(
		.MAX_TIMEOUTS(MAX_TIMEOUTS),
		.SIZE_FIELD_CHARS(SIZE_FIELD_CHARS)
	) u_core (
		.clk(clk), .arst_n(arst_n), .ev_accept(ev_accept),
		.operation(in_ch.operation), .rx_byte(in_ch.rx_byte),
		.max_size(max_size_q), .res(pair)
	);

	ymr_outq u_outq (
		.clk(clk), .arst_n(arst_n), .push(ev_accept), .pair(pair), .room(room),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
	);
endmodule

// ===== hdl/ymr_checker.sv =====
// Port-level checks for the YModem receiver, bound to the top level.
// Depends on ymr_pkg and ymodem_receiver.
module ymr_props (
	input logic          clk,
	input logic          arst_n,
	input logic          out_valid,
	input logic          out_ready,
	input ymr_pkg::res_t out_data
);
	logic done_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_seen_q <= 1'b0;
		else if (out_valid && out_ready && out_data.done_res) done_seen_q <= 1'b1;
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_seen_q |-> out_data.done_res)
		else $error("session reopened after end");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.done_res == (out_data.status != ymr_pkg::ST_RUN)))
		else $error("status disagrees with done");

	a_second: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last |-> out_data.tx_valid)
		else $error("non-final item without reply byte");
endmodule

bind ymodem_receiver ymr_props u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_ch.valid),
	.out_ready(out_ch.ready), .out_data(out_ch.data)
);

// ===== dv/ymr_checker.sv =====
// Scoreboard for the YModem receiver: watches the event, result and config
// channels, predicts each result item and compares. Depends on ymr_pkg, ymr_if.
`timescale 1ns / 100ps

module ymr_checker #(
	parameter int MAX_TIMEOUTS = 5,
	parameter int SIZE_FIELD_CHARS = 16
) (
	input logic clk,
	input logic arst_n,
	ymr_in_if   in_ch,
	ymr_out_if  out_ch,
	ymr_cfg_if  cfg_ch,
	output int  fail_count,
	output int  pending
);
	ymr_pkg::res_t reply_q[$];

	// session state
	logic [2:0]  phase;
	logic [10:0] idx;
	logic        long_pkt;
	logic [7:0]  seq_no, seq_cmp, pkt_count;
	logic [15:0] crc;
	logic        hdr_taken, name_set, over, ovf;
	logic [3:0]  err_cnt, stat;
	logic [1:0]  eots, field;
	logic [4:0]  digits;
	ymr_pkg::size_t size_exp, committed, max_len, accum;

	// per-event outputs
	logic [7:0] tx[2];
	int         ntx;
	logic       wr_v, commit_v;
	ymr_pkg::size_t wr_addr;
	logic [7:0] wr_data;

	function void send(logic [7:0] b);
		if (ntx < 2) begin
			tx[ntx] = b;
			ntx++;
		end
	endfunction

	function void close(logic [3:0] st);
		over = 1'b1;
		stat = st;
		phase = ymr_pkg::PH_OVER;
	endfunction

	function void abort(logic [3:0] st);
		send(ymr_pkg::B_CA);
		send(ymr_pkg::B_CA);
		close(st);
	endfunction

	function void bump_error(int limit, logic [3:0] st, logic [7:0] b);
		int n;
		n = err_cnt + 1;
		if (n > limit) abort(st);
		else begin
			err_cnt = (n > 15) ? 4'd15 : n[3:0];
			send(b);
		end
	endfunction

	function void on_timeout();
		if (eots > 1) close(ymr_pkg::ST_OK);
		else bump_error(MAX_TIMEOUTS, ymr_pkg::ST_TIMEOUT, ymr_pkg::B_C);
	endfunction

	function void header_byte(int p, logic [7:0] b);
		longint unsigned v;
		if (p == 0) name_set = (b != 8'h00);
		if (field == ymr_pkg::HF_NAME) begin
			if (b == 8'h00) field = ymr_pkg::HF_SIZE;
		end else if (field == ymr_pkg::HF_SIZE) begin
			if (b >= "0" && b <= "9" && digits < SIZE_FIELD_CHARS) begin
				v = longint'(accum) * 10 + (b - "0");
				if (v > 64'hFF_FFFF) begin
					ovf = 1'b1;
					accum = '1;
				end else accum = v[23:0];
				digits++;
			end else field = ymr_pkg::HF_REST;
		end
	endfunction

	function void packet_end(int psize);
		logic [24:0] sum;
		if (!(seq_no == ~seq_cmp && crc == 16'h0))
			bump_error(ymr_pkg::ERROR_LIMIT, ymr_pkg::ST_CRC, ymr_pkg::B_NAK);
		else if (eots > 1) send(ymr_pkg::B_ACK);
		else if (seq_no != pkt_count)
			bump_error(ymr_pkg::ERROR_LIMIT, ymr_pkg::ST_SEQ, ymr_pkg::B_NAK);
		else if (!hdr_taken) begin
			if (!name_set) bump_error(ymr_pkg::ERROR_LIMIT, ymr_pkg::ST_EMPTY, ymr_pkg::B_NAK);
			else begin
				err_cnt = '0;
				size_exp = accum;
				if (ovf || accum > max_len) begin
					abort(ymr_pkg::ST_LARGE);
					return;
				end
				if (accum == '0) begin
					abort(ymr_pkg::ST_ZERO);
					return;
				end
				committed = '0;
				send(ymr_pkg::B_ACK);
				send(ymr_pkg::B_C);
			end
			hdr_taken = 1'b1;
			pkt_count++;
		end else begin
			sum = committed + psize;
			committed = (sum >= size_exp) ? size_exp : sum[23:0];
			err_cnt = '0;
			commit_v = 1'b1;
			send(ymr_pkg::B_ACK);
			pkt_count++;
		end
	endfunction

	function void packet_byte(logic [7:0] b);
		int psize, p;
		psize = long_pkt ? 1024 : 128;
		if (idx == 0) seq_no = b;
		else if (idx == 1) seq_cmp = b;
		else begin
			p = idx - 2;
			crc ^= {b, 8'h00};
			for (int i = 0; i < 8; i++)
				crc = crc[15] ? ({crc[14:0], 1'b0} ^ 16'h1021) : {crc[14:0], 1'b0};
			if (p < psize) begin
				header_byte(p, b);
				if (hdr_taken && eots < 2 && seq_no == pkt_count && seq_no == ~seq_cmp &&
				    (longint'(committed) + p) < longint'(size_exp)) begin
					wr_v = 1'b1;
					wr_addr = committed + p;
					wr_data = b;
				end
			end
		end
		if (idx >= psize + 3) begin
			phase = ymr_pkg::PH_IDLE;
			packet_end(psize);
		end else idx++;
	endfunction

	function void idle_byte(logic [7:0] b);
		case (b)
			ymr_pkg::B_SOH, ymr_pkg::B_STX: begin
				phase = ymr_pkg::PH_PKT;
				long_pkt = (b == ymr_pkg::B_STX);
				idx = '0;
				crc = '0;
				field = ymr_pkg::HF_NAME;
				digits = '0;
				accum = '0;
				name_set = 1'b0;
				ovf = 1'b0;
			end
			ymr_pkg::B_EOT: begin
				if (eots < 2) eots++;
				if (eots == 1) send(ymr_pkg::B_NAK);
				else begin
					send(ymr_pkg::B_ACK);
					send(ymr_pkg::B_C);
				end
			end
			ymr_pkg::B_CA: phase = ymr_pkg::PH_CAN;
			ymr_pkg::B_UA, ymr_pkg::B_LA: abort(ymr_pkg::ST_USER);
			default: phase = ymr_pkg::PH_DRAIN;
		endcase
	endfunction

	// Advance the session by one event and queue its result items
	function void predict_event(logic op, logic [7:0] b);
		ymr_pkg::res_t r;
		int n;
		ntx = 0;
		wr_v = 1'b0;
		commit_v = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		case (phase)
			ymr_pkg::PH_IDLE: if (op) on_timeout(); else idle_byte(b);
			ymr_pkg::PH_CAN: begin
				if (op) abort(ymr_pkg::ST_USER);
				else if (b == ymr_pkg::B_CA) begin
					send(ymr_pkg::B_ACK);
					close(ymr_pkg::ST_SENDER);
				end else begin
					phase = ymr_pkg::PH_IDLE;
					on_timeout();
				end
			end
			ymr_pkg::PH_PKT: begin
				if (op) begin
					phase = ymr_pkg::PH_IDLE;
					on_timeout();
				end else packet_byte(b);
			end
			ymr_pkg::PH_DRAIN: begin
				if (op) begin
					phase = ymr_pkg::PH_IDLE;
					on_timeout();
				end
			end
			default: ;
		endcase
		n = (ntx > 1) ? ntx : 1;
		for (int k = 0; k < n; k++) begin
			r.tx_valid = (k < ntx);
			r.tx_byte = (k < ntx) ? tx[k] : 8'h00;
			r.write_valid = (k == 0) && wr_v;
			r.write_addr = (k == 0 && wr_v) ? wr_addr : '0;
			r.write_data = (k == 0 && wr_v) ? wr_data : '0;
			r.commit_valid = (k == 0) && commit_v;
			r.received_length = committed;
			r.done_res = over;
			r.status = stat;
			r.hdr_size = size_exp;
			r.last = (k == n - 1);
			reply_q.push_back(r);
		end
	endfunction

	function void check_field(string name, longint unsigned want, longint unsigned got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ymr_pkg::res_t want, got;
		if (!arst_n) begin
			idx = '0; long_pkt = 0; seq_no = '0; seq_cmp = '0; crc = '0;
			pkt_count = '0; hdr_taken = 0; err_cnt = '0; eots = '0;
			size_exp = '0; committed = '0; field = ymr_pkg::HF_NAME; digits = '0;
			accum = '0; name_set = 0; over = 0; ovf = 0; stat = ymr_pkg::ST_RUN;
			max_len = 24'd3072;
			phase = ymr_pkg::PH_IDLE;
			reply_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// compare first: results leave a registered queue, always after their event
			if (out_ch.valid && out_ch.ready) begin
				got = out_ch.data;
				if (reply_q.size() == 0) begin
					$error("result item with no expectation waiting");
					fail_count++;
				end else begin
					want = reply_q.pop_front();
					check_field("tx_valid", want.tx_valid, got.tx_valid);
					check_field("tx_byte", want.tx_byte, got.tx_byte);
					check_field("write_valid", want.write_valid, got.write_valid);
					check_field("write_addr", want.write_addr, got.write_addr);
					check_field("write_data", want.write_data, got.write_data);
					check_field("commit_valid", want.commit_valid, got.commit_valid);
					check_field("received_length", want.received_length,
						got.received_length);
					check_field("done_res", want.done_res, got.done_res);
					check_field("status", want.status, got.status);
					check_field("hdr_size", want.hdr_size, got.hdr_size);
					check_field("last", want.last, got.last);
				end
			end
			if (cfg_ch.valid && cfg_ch.ready) max_len = cfg_ch.data;
			if (in_ch.valid && in_ch.ready) predict_event(in_ch.operation, in_ch.rx_byte);
			pending = reply_q.size();
		end
	end

endmodule

// ===== dv/testbench.sv =====
// Top of the YModem receiver testbench: clock, reset, event stimulus, result
// back-pressure and verdict. Depends on ymr_pkg, ymr_if, ymr_checker, the RTL.
`timescale 1ns / 100ps

module testbench;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TIMEOUT = 1'b1;

	// packet faults the generator can inject
	typedef enum int {
		FLT_NONE, FLT_CRC, FLT_COMPL, FLT_SEQ, FLT_CUT
	} fault_t;

	logic clk;
	logic arst_n;
	int   fail_count, pending;
	int   events_sent;
	int   err_budget;   // our own tally, keeps random faults below the abort limit
	bit   quiet;        // no sender gaps while set
	logic [7:0] next_seq;

	ymr_in_if  in_ch();
	ymr_out_if out_ch();
	ymr_cfg_if cfg_ch();

	ymodem_receiver dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
	);

	ymr_checker chk (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop well past the slowest legal run
	initial begin
		#3ms;
		$display("FAIL");
		$finish;
	end

	// Offer one event; hold valid across back-to-back transactions
	task automatic put(logic op, logic [7:0] b);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.operation <= op;
		in_ch.rx_byte <= op ? 8'($urandom) : b;
		do @(posedge clk); while (!in_ch.ready);
		events_sent++;
	endtask

	// Drain everything in flight, then write the size limit
	task automatic write_limit(ymr_pkg::size_t v);
		@(negedge clk);
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
		c ^= {b, 8'h00};
		for (int i = 0; i < 8; i++) c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
		return c;
	endfunction

	// Frame and send one packet, random padding after the given bytes
	task automatic send_packet(bit long_pkt, logic [7:0] seq, logic [7:0] body[$],
		fault_t flt);
		int psize, cut;
		logic [15:0] c;
		logic [7:0] b;
		psize = long_pkt ? 1024 : 128;
		// cut early in the payload so a dropped long packet stays short
		cut = $urandom_range(0, 127);
		c = '0;
		put(OP_BYTE, long_pkt ? ymr_pkg::B_STX : ymr_pkg::B_SOH);
		put(OP_BYTE, flt == FLT_SEQ ? seq + 8'd7 : seq);
		put(OP_BYTE, flt == FLT_COMPL ? seq : ~seq);
		for (int p = 0; p < psize; p++) begin
			b = (p < body.size()) ? body[p] : 8'($urandom);
			c = crc_step(c, b);
			if (flt == FLT_CUT && p == cut) begin
				put(OP_TIMEOUT, 8'h00);
				return;
			end
			put(OP_BYTE, b);
		end
		if (flt == FLT_CRC) c ^= 16'(1 << $urandom_range(0, 15));
		put(OP_BYTE, c[15:8]);
		put(OP_BYTE, c[7:0]);
	endtask

	// Data packet with the next sequence number; tracks our error tally
	task automatic data_packet(bit long_pkt, fault_t flt);
		logic [7:0] none[$];
		send_packet(long_pkt, next_seq, none, flt);
		if (flt == FLT_NONE) begin
			next_seq++;
			err_budget = 0;
		end else err_budget++;
	endtask

	// Sender: directed opening, random session body, one terminal ending
	initial begin
		logic [7:0] hdr[$];
		logic [7:0] none[$];
		int fsize, r;
		string digits;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.operation = OP_BYTE;
		in_ch.rx_byte = 8'h00;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		events_sent = 0;
		err_budget = 0;
		quiet = 0;
		next_seq = 8'd0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// Limit extremes while nothing depends on them yet
		write_limit(24'h000000);
		write_limit(24'hFFFFFF);

		// Timeout, unknown start byte with a drained tail, CA then other byte
		put(OP_TIMEOUT, 8'h00);
		put(OP_BYTE, 8'h7E);
		put(OP_BYTE, ymr_pkg::B_SOH);
		put(OP_BYTE, ymr_pkg::B_CA);
		put(OP_TIMEOUT, 8'h00);
		put(OP_BYTE, ymr_pkg::B_CA);
		put(OP_BYTE, 8'h55);
		// Header with a broken CRC: NAK, errors now at four
		send_packet(1'b0, 8'd0, none, FLT_CRC);

		// Good header: name, NUL, decimal size, space
		fsize = $urandom_range(300, 900);
		digits = $sformatf("%0d", fsize);
		hdr = '{"f", ".", "b", "i", "n", 8'h00};
		for (int i = 0; i < digits.len(); i++) hdr.push_back(digits[i]);
		hdr.push_back(" ");
		for (int i = 0; i < 20; i++) hdr.push_back(8'h00);
		send_packet(1'b0, 8'd0, hdr, FLT_NONE);
		next_seq = 8'd1;

		write_limit(24'($urandom));
		put(OP_BYTE, ymr_pkg::B_EOT);   // single EOT: NAK only
		data_packet(1'b1, FLT_CUT);     // long packet dropped by a timeout
		write_limit(24'd3072);

		// Random body: mostly good packets, some broken ones and line noise
		while (events_sent < 560) begin
			quiet = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 9);
			if (r < 6 || err_budget >= 3) data_packet(1'b0, FLT_NONE);
			else if (r == 6) begin
				put(OP_BYTE, 8'($urandom_range(8'h05, 8'h17)) | 8'h80);
				repeat ($urandom_range(1, 6)) put(OP_BYTE, 8'($urandom));
				put(OP_TIMEOUT, 8'h00);
				err_budget++;
			end else data_packet(1'b0, fault_t'($urandom_range(FLT_CRC, FLT_CUT)));
		end
		quiet = 0;

		// End the session one of several ways
		case ($urandom_range(0, 3))
			0: begin
				put(OP_BYTE, ymr_pkg::B_EOT);
				data_packet(1'b0, FLT_NONE);   // after two EOTs: ACK only
				put(OP_TIMEOUT, 8'h00);
			end
			1: begin
				put(OP_BYTE, ymr_pkg::B_CA);
				put(OP_BYTE, ymr_pkg::B_CA);
			end
			2: put(OP_BYTE, $urandom_range(0, 1) ? ymr_pkg::B_UA : ymr_pkg::B_LA);
			default: begin
				put(OP_BYTE, ymr_pkg::B_CA);
				put(OP_TIMEOUT, 8'h00);
			end
		endcase
		// Events after the end only report the final status
		repeat (4) put(1'($urandom), 8'($urandom));
		@(negedge clk);
		in_ch.valid <= 1'b0;

		do @(posedge clk); while (pending != 0);
		repeat (20) @(posedge clk);
		if (fail_count == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

	// Receiver: random stall per transaction, two long hold-offs to fill the queue
	initial begin
		int gap, taken;
		out_ch.ready = 1'b0;
		taken = 0;
		@(posedge arst_n);
		forever begin
			if (taken == 150 || taken == 500) gap = 80;
			else if ((taken / 40) % 3 == 2) gap = 0;
			else gap = $urandom_range(0, 11);
			if (gap > 0) begin
				@(negedge clk);
				out_ch.ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			taken++;
		end
	end

endmodule
